>>> hdl/lgdfb_pkg.sv
// ----------------------------------------------------------------------------
// lgdfb_pkg
// Types, codes and sizes shared by the grayscale frame builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lgdfb_pkg;

   localparam int LED_COUNT   = 8;
   localparam int CHANNELS    = 3 * LED_COUNT;
   localparam int LEVEL_BITS  = 8;
   localparam int GRAY_BITS   = 12;
   localparam int LEVEL_SHIFT = GRAY_BITS - LEVEL_BITS;
   localparam int DIM_BITS    = 8;
   localparam int GAIN_BITS   = 2 * DIM_BITS;
   localparam int PROD_BITS   = GRAY_BITS + GAIN_BITS;
   localparam int INDEX_W     = 5;
   localparam int LED_W       = $clog2(LED_COUNT);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      FUNC_SET_LEVEL   = 3'd0,
      FUNC_SET_LED_RGB = 3'd1,
      FUNC_SET_ALL_RGB = 3'd2,
      FUNC_CLEAR       = 3'd3,
      FUNC_SET_DIM     = 3'd4,
      FUNC_SET_LED_DIM = 3'd5,
      FUNC_UPDATE      = 3'd6
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLOT_FIRST  = 2'd0,
      CSR_SLOT_SECOND = 2'd1,
      CSR_SLOT_THIRD  = 2'd2,
      CSR_GLOBAL_DIM  = 2'd3
   } csr_index_type;

   // colour source codes; the spare code reads as a zero word
   localparam logic [1:0] COLOR_RED   = 2'd0;
   localparam logic [1:0] COLOR_GREEN = 2'd1;
   localparam logic [1:0] COLOR_BLUE  = 2'd2;
   localparam logic [1:0] COLOR_NONE  = 2'd3;

   localparam logic [DIM_BITS-1:0] DIM_FULL = '1;

   typedef struct packed {
      logic [2:0]            func;
      logic [INDEX_W-1:0]    index;
      logic [LEVEL_BITS-1:0] value;
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [GRAY_BITS-1:0] gray_word;
      logic                 last;
   } rsp_type;

   // validated command; chan is the first channel touched (LED index * 3 for LED ops)
   typedef struct packed {
      func_type              op;
      logic [INDEX_W-1:0]    chan;
      logic [LEVEL_BITS-1:0] value;
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
   } cmd_type;

endpackage

`default_nettype wire

>>> hdl/led_grayscale_dim_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// led_grayscale_dim_frame_builder_unit
// Grayscale frame builder for a 24-channel PWM LED driver with dimming.
// ----------------------------------------------------------------------------
// Request items (req_valid/req_stall/req_data) write levels or dims, clear
// the levels, or ask for an update. Items with an unused code or an index out
// of range are dropped. The front checks each item and puts it in a 4-entry
// command queue; req_stall is high only while that queue is full.
// The back takes one command per cycle while idle; a write is registered
// as it is dequeued. An update is dequeued, then the sequencer reads the
// 24 channels in turn, channel 23 first; the final word has last set.
// The update's first word passes the state register, the stage-1 register
// and the output register before it shows on rsp_valid/rsp_data. Each word
// passes a two-stage scaling pipe: global dim times channel dim, then word
// times gain into the output register (unscaled when both dims are full).
// While rsp_valid and rsp_stall are high, the scaling pipe and sequencer hold;
// writes queued behind an update wait until the update has read all channels.
// csr_* writes colour order and global dim; write them only while idle.
// Synchronous reset: levels zero, dims 255, identity colour order, global
// dim 255, queue and pipe empty.
// ----------------------------------------------------------------------------
`default_nettype none

module led_grayscale_dim_frame_builder_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire lgdfb_pkg::req_type            req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output lgdfb_pkg::rsp_type                 rsp_data,
   input  wire                                csr_we,
   input  wire  [lgdfb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [lgdfb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                push, pop, queue_empty, queue_full;
   lgdfb_pkg::cmd_type  push_cmd, head_cmd;

   lgdfb_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   lgdfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   lgdfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .pop         (pop),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

>>> hdl/lgdfb_front.sv
// ----------------------------------------------------------------------------
// lgdfb_front
// Accepts request items, drops unused codes and out-of-range writes, and
// turns the rest into commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lgdfb_front (
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire lgdfb_pkg::req_type  req_data,
   input  wire                      queue_full,
   output logic                     push,
   output lgdfb_pkg::cmd_type       push_cmd
);

   logic                             cmd_ok;
   logic [lgdfb_pkg::INDEX_W-1:0]    led_base;

   assign led_base = (req_data.index << 1) + req_data.index;

   always_comb begin
      cmd_ok         = 1'b0;
      push_cmd.op    = lgdfb_pkg::func_type'(req_data.func);
      push_cmd.chan  = req_data.index;
      push_cmd.value = req_data.value;
      push_cmd.red   = req_data.red;
      push_cmd.green = req_data.green;
      push_cmd.blue  = req_data.blue;
      unique case (req_data.func) inside
         lgdfb_pkg::FUNC_SET_LEVEL, lgdfb_pkg::FUNC_SET_DIM: begin
            cmd_ok = req_data.index < lgdfb_pkg::INDEX_W'(lgdfb_pkg::CHANNELS);
         end
         lgdfb_pkg::FUNC_SET_LED_RGB, lgdfb_pkg::FUNC_SET_LED_DIM: begin
            cmd_ok        = req_data.index < lgdfb_pkg::INDEX_W'(lgdfb_pkg::LED_COUNT);
            push_cmd.chan = led_base;
         end
         lgdfb_pkg::FUNC_SET_ALL_RGB, lgdfb_pkg::FUNC_CLEAR, lgdfb_pkg::FUNC_UPDATE: begin
            cmd_ok = 1'b1;
         end
         default: begin
            cmd_ok = 1'b0;
         end
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && cmd_ok;

endmodule

`default_nettype wire

>>> hdl/lgdfb_queue.sv
// ----------------------------------------------------------------------------
// lgdfb_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lgdfb_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire lgdfb_pkg::cmd_type  push_cmd,
   input  wire                      pop,
   output lgdfb_pkg::cmd_type       head_cmd,
   output logic                     empty,
   output logic                     full
);

   lgdfb_pkg::cmd_type                entry_ff [lgdfb_pkg::QUEUE_DEPTH];
   logic [lgdfb_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [lgdfb_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [lgdfb_pkg::QPTR_W:0]        count_ff, count_in;
   logic                              do_push, do_pop;

   assign empty    = count_ff == '0;
   assign full     = count_ff == (lgdfb_pkg::QPTR_W + 1)'(lgdfb_pkg::QUEUE_DEPTH);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> hdl/lgdfb_back.sv
// ----------------------------------------------------------------------------
// lgdfb_back
// Executes queued commands: level and dim writes, and the update sequencer
// that walks the channels high to low through a two-stage scaling pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module lgdfb_back (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire lgdfb_pkg::cmd_type               head_cmd,
   input  wire                                   queue_empty,
   output logic                                  pop,
   input  wire                                   csr_we,
   input  wire  [lgdfb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [lgdfb_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output lgdfb_pkg::rsp_type                    rsp_data
);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type                                state_ff;
   logic [lgdfb_pkg::LED_W-1:0]              led_ff;
   logic [1:0]                               slot_ff;

   logic [1:0]                               color_slot_ff [3];
   logic [lgdfb_pkg::DIM_BITS-1:0]           global_dim_ff;

   logic [lgdfb_pkg::LEVEL_BITS-1:0]         level_ff [lgdfb_pkg::CHANNELS];
   logic [lgdfb_pkg::LEVEL_BITS-1:0]         level_in [lgdfb_pkg::CHANNELS];
   logic [lgdfb_pkg::DIM_BITS-1:0]           dim_ff   [lgdfb_pkg::CHANNELS];
   logic [lgdfb_pkg::DIM_BITS-1:0]           dim_in   [lgdfb_pkg::CHANNELS];

   logic                                     s1_valid_ff;
   logic [lgdfb_pkg::GRAY_BITS-1:0]          s1_word_ff;
   logic [lgdfb_pkg::GAIN_BITS-1:0]          s1_gain_ff;
   logic                                     s1_bypass_ff;
   logic                                     s1_last_ff;
   logic                                     rsp_valid_ff;
   lgdfb_pkg::rsp_type                       rsp_data_ff;

   logic                                     adv, issue, exec;
   logic [lgdfb_pkg::INDEX_W-1:0]            led_base, pos, src_chan;
   logic [1:0]                               src;
   logic [lgdfb_pkg::LEVEL_BITS-1:0]         src_level;
   logic [lgdfb_pkg::GRAY_BITS-1:0]          word_a;
   logic [lgdfb_pkg::DIM_BITS-1:0]           dim_a;
   logic [lgdfb_pkg::PROD_BITS-1:0]          prod;

   // the pipe moves as one while the output register is free
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign issue = (state_ff == ST_UPDATE) && adv;
   assign pop   = (state_ff == ST_IDLE) && !queue_empty;
   assign exec  = pop && (head_cmd.op != lgdfb_pkg::FUNC_UPDATE);

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         color_slot_ff[0] <= lgdfb_pkg::COLOR_RED;
         color_slot_ff[1] <= lgdfb_pkg::COLOR_GREEN;
         color_slot_ff[2] <= lgdfb_pkg::COLOR_BLUE;
         global_dim_ff    <= lgdfb_pkg::DIM_FULL;
      end else if (csr_we) begin
         unique case (lgdfb_pkg::csr_index_type'(csr_index))
            lgdfb_pkg::CSR_SLOT_FIRST:  color_slot_ff[0] <= csr_wdata[1:0];
            lgdfb_pkg::CSR_SLOT_SECOND: color_slot_ff[1] <= csr_wdata[1:0];
            lgdfb_pkg::CSR_SLOT_THIRD:  color_slot_ff[2] <= csr_wdata[1:0];
            lgdfb_pkg::CSR_GLOBAL_DIM:  global_dim_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- update sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         led_ff   <= '0;
         slot_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (pop && head_cmd.op == lgdfb_pkg::FUNC_UPDATE) begin
                  state_ff <= ST_UPDATE;
                  led_ff   <= lgdfb_pkg::LED_W'(lgdfb_pkg::LED_COUNT - 1);
                  slot_ff  <= 2'd2;
               end
            end
            ST_UPDATE: begin
               if (adv) begin
                  if (slot_ff == 2'd0) begin
                     slot_ff <= 2'd2;
                     if (led_ff == '0) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        led_ff <= led_ff - 1'b1;
                     end
                  end else begin
                     slot_ff <= slot_ff - 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign led_base = (lgdfb_pkg::INDEX_W'(led_ff) << 1) + lgdfb_pkg::INDEX_W'(led_ff);
   assign pos      = led_base + lgdfb_pkg::INDEX_W'(slot_ff);

   always_comb begin
      case (slot_ff)
         2'd0:    src = color_slot_ff[0];
         2'd1:    src = color_slot_ff[1];
         2'd2:    src = color_slot_ff[2];
         default: src = lgdfb_pkg::COLOR_NONE;
      endcase
   end

   assign src_chan  = led_base + lgdfb_pkg::INDEX_W'(src);
   assign src_level = (src == lgdfb_pkg::COLOR_NONE) ? '0 : level_ff[src_chan];
   assign word_a    = lgdfb_pkg::GRAY_BITS'(src_level) << lgdfb_pkg::LEVEL_SHIFT;
   assign dim_a     = dim_ff[pos];

   // ---- level and dim writes ----
   always_comb begin
      level_in = level_ff;
      dim_in   = dim_ff;
      if (exec) begin
         unique case (head_cmd.op)
            lgdfb_pkg::FUNC_SET_LEVEL: begin
               level_in[head_cmd.chan] = head_cmd.value;
            end
            lgdfb_pkg::FUNC_SET_LED_RGB: begin
               level_in[head_cmd.chan]        = head_cmd.red;
               level_in[head_cmd.chan + 5'd1] = head_cmd.green;
               level_in[head_cmd.chan + 5'd2] = head_cmd.blue;
            end
            lgdfb_pkg::FUNC_SET_ALL_RGB: begin
               for (int i = 0; i < lgdfb_pkg::LED_COUNT; i++) begin
                  level_in[3*i]     = head_cmd.red;
                  level_in[3*i + 1] = head_cmd.green;
                  level_in[3*i + 2] = head_cmd.blue;
               end
            end
            lgdfb_pkg::FUNC_CLEAR: begin
               for (int i = 0; i < lgdfb_pkg::CHANNELS; i++) begin
                  level_in[i] = '0;
               end
            end
            lgdfb_pkg::FUNC_SET_DIM: begin
               dim_in[head_cmd.chan] = head_cmd.value;
            end
            lgdfb_pkg::FUNC_SET_LED_DIM: begin
               dim_in[head_cmd.chan]        = head_cmd.value;
               dim_in[head_cmd.chan + 5'd1] = head_cmd.value;
               dim_in[head_cmd.chan + 5'd2] = head_cmd.value;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lgdfb_pkg::CHANNELS; i++) begin
            level_ff[i] <= '0;
            dim_ff[i]   <= lgdfb_pkg::DIM_FULL;
         end
      end else begin
         level_ff <= level_in;
         dim_ff   <= dim_in;
      end
   end

   // ---- scaling pipe: gain product, then word times gain ----
   assign prod = s1_word_ff * s1_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= issue;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_word_ff   <= word_a;
         s1_gain_ff   <= global_dim_ff * dim_a;
         s1_bypass_ff <= (global_dim_ff == lgdfb_pkg::DIM_FULL) &&
                         (dim_a == lgdfb_pkg::DIM_FULL);
         s1_last_ff   <= pos == '0;
         rsp_data_ff.gray_word <= s1_bypass_ff ? s1_word_ff :
                                  prod[lgdfb_pkg::PROD_BITS-1 -: lgdfb_pkg::GRAY_BITS];
         rsp_data_ff.last      <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
